### hw/rtl/bagelu_pkg.sv
// shared types, codes and the saturation helper for the bias add + gelu block
// no dependencies
`default_nettype none

package bagelu_pkg;

    // item kinds carried in tuser
    typedef enum logic [1:0] {
        FUNC_LOAD_BIAS = 2'd0,
        FUNC_LOAD_COEF = 2'd1,
        FUNC_EVAL      = 2'd2
    } t_func;

    // coefficient selector codes
    localparam logic [1:0] COEF_QUAD  = 2'd0;
    localparam logic [1:0] COEF_LIN   = 2'd1;
    localparam logic [1:0] COEF_CONST = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_RANGE_LOW  = 2'd0;
    localparam logic [1:0] CFG_RANGE_HIGH = 2'd1;
    localparam logic [1:0] CFG_SEG_SCALE  = 2'd2;

    localparam int DataW = 32;

    // per-stage control that travels down the pipeline
    typedef struct packed {
        logic       eval;
        logic       last;
        logic [2:0] coef_we;   // one-hot: quad, lin, const
    } t_ctl;

    typedef struct packed {
        logic [DataW-1:0] val;
        logic             clip;
    } t_sat;

    typedef struct packed {
        logic [DataW-1:0] result;
        logic             last;
        logic             sat;
    } t_res;

    // clip a 49-bit signed sum to the signed 32-bit range
    function automatic t_sat sat_q16(input logic signed [48:0] v);
        t_sat s;
        if (v[48:31] == {18{v[48]}}) begin
            s.val  = v[31:0];
            s.clip = 1'b0;
        end else begin
            s.val  = v[48] ? 32'h8000_0000 : 32'h7fff_ffff;
            s.clip = 1'b1;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/bias_add_piecewise_quadratic_gelu.sv
// bias add followed by gelu through a loaded piecewise quadratic table
// depends on bagelu_pkg
`default_nettype none

// Usage
//   Input stream (s_axis): tuser selects the item kind: load a bias word for a
//   column, load one coefficient of a segment, or evaluate an activation.
//   Load items change the bias memory or the coefficient tables and produce
//   nothing; an evaluate item produces exactly one transfer on m_axis.
//   Configuration (range_low, range_high, segment_scale) must be written by the user
//   through the cfg port while no evaluate is outstanding; the block does not enforce it.
//   An evaluate item passes through bias read, add, clamp, offset, scale
//   multiply, coefficient read and two multiply/saturate pairs, then into the
//   output queue. Throughput is one item per cycle while s_axis_tready is high;
//   the pipeline never stalls, and one result may leave per cycle.
//   Results land in a 16-entry output queue. s_axis_tready drops only while
//   16 evaluate results are accepted but not yet taken, so a stalled receiver
//   throttles the input without losing anything.
//   Reset clears the pipeline, the queue and the configuration registers to
//   -8.0, 8.0 and 16.0; the bias memory and coefficient tables are not
//   cleared and must be loaded before they are used.
module bias_add_piecewise_quadratic_gelu
    import bagelu_pkg::*;
#(
    parameter int MAX_COLUMNS = 4096,
    parameter int SEGMENTS    = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write port
    input  wire logic        i_cfg_wr_en,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_wdata,
    // input stream
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [47:0] i_s_axis_tdata,   // position[11:0], value[43:12], zero pad
    input  wire logic [3:0]  i_s_axis_tuser,   // func[1:0], coef_select[3:2]
    input  wire logic        i_s_axis_tlast,   // last_in_row
    // result stream
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [31:0]      o_m_axis_tdata,   // result[31:0]
    output logic [0:0]       o_m_axis_tuser,   // saturated[0]
    output logic             o_m_axis_tlast    // row_end
);

    localparam int COL_W   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int SEG_W   = $clog2(SEGMENTS);
    localparam int DEPTH   = 16;
    localparam int PTR_W   = $clog2(DEPTH);
    localparam int CNT_W   = PTR_W + 1;

    // configuration
    logic signed [31:0] r_range_low;
    logic signed [31:0] r_range_high;
    logic [31:0]        r_seg_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_low  <= 32'shfff8_0000;
            r_range_high <= 32'sh0008_0000;
            r_seg_scale  <= 32'h0010_0000;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_RANGE_LOW:  r_range_low  <= i_cfg_wdata;
                CFG_RANGE_HIGH: r_range_high <= i_cfg_wdata;
                CFG_SEG_SCALE:  r_seg_scale  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // input decode
    logic [1:0]         w_func;
    logic [1:0]         w_sel;
    logic [11:0]        w_pos;
    logic [31:0]        w_val;
    logic               w_acc;
    logic               w_col_ok;
    logic               w_seg_ok;
    t_ctl               w_ctl_in;
    logic               w_pop;
    logic [CNT_W-1:0]   r_count;

    assign w_func   = i_s_axis_tuser[1:0];
    assign w_sel    = i_s_axis_tuser[3:2];
    assign w_pos    = i_s_axis_tdata[11:0];
    assign w_val    = i_s_axis_tdata[43:12];
    assign w_acc    = i_s_axis_tvalid && o_s_axis_tready;
    assign w_col_ok = {5'd0, w_pos} < 17'(MAX_COLUMNS);
    assign w_seg_ok = {1'b0, w_pos} < 13'(SEGMENTS);

    always_comb begin
        w_ctl_in      = '0;
        w_ctl_in.eval = w_acc && (w_func == FUNC_EVAL);
        w_ctl_in.last = i_s_axis_tlast;
        if (w_acc && (w_func == FUNC_LOAD_COEF) && w_seg_ok) begin
            case (w_sel)
                COEF_QUAD:  w_ctl_in.coef_we = 3'b001;
                COEF_LIN:   w_ctl_in.coef_we = 3'b010;
                COEF_CONST: w_ctl_in.coef_we = 3'b100;
                default:    w_ctl_in.coef_we = 3'b000;
            endcase
        end
    end

    // control pipeline
    t_ctl r_ctl1, r_ctl2, r_ctl3, r_ctl4, r_ctl5, r_ctl6, r_ctl7, r_ctl8, r_ctl9;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
            r_ctl3 <= '0;
            r_ctl4 <= '0;
            r_ctl5 <= '0;
            r_ctl6 <= '0;
            r_ctl7 <= '0;
            r_ctl8 <= '0;
            r_ctl9 <= '0;
        end else begin
            r_ctl1 <= w_ctl_in;
            r_ctl2 <= r_ctl1;
            r_ctl3 <= r_ctl2;
            r_ctl4 <= r_ctl3;
            r_ctl5 <= r_ctl4;
            r_ctl6 <= r_ctl5;
            r_ctl7 <= r_ctl6;
            r_ctl8 <= r_ctl7;
            r_ctl9 <= r_ctl8;
        end
    end

    // stage 1: bias memory, written by loads and read by evaluates in order
    logic [31:0]        r_bias_mem [MAX_COLUMNS];
    logic [COL_W-1:0]   w_col_addr;
    logic [31:0]        r_bias_rd;
    logic               r_bias_ok1;
    logic signed [31:0] r_val1;
    logic [SEG_W-1:0]   r_caddr1;

    assign w_col_addr = COL_W'(w_pos);

    always_ff @(posedge i_clk) begin
        if (w_acc && (w_func == FUNC_LOAD_BIAS) && w_col_ok) begin
            r_bias_mem[w_col_addr] <= w_val;
        end
        r_bias_rd  <= r_bias_mem[w_col_addr];
        r_bias_ok1 <= (w_func == FUNC_EVAL) && w_col_ok;
        r_val1     <= w_val;
        r_caddr1   <= SEG_W'(w_pos);
    end

    // stage 2: exact bias add (loads pass their value through)
    logic signed [31:0] w_bias;
    logic signed [32:0] r_sum2;
    logic [SEG_W-1:0]   r_caddr2;

    assign w_bias = r_bias_ok1 ? r_bias_rd : '0;

    always_ff @(posedge i_clk) begin
        r_sum2   <= 33'(r_val1) + 33'(w_bias);
        r_caddr2 <= r_caddr1;
    end

    // stage 3: clamp, low bound first then high bound
    logic signed [32:0] w_lo_clamp;
    logic signed [32:0] w_hi_clamp;
    logic signed [31:0] r_x3;
    logic [SEG_W-1:0]   r_caddr3;

    assign w_lo_clamp = (r_sum2 < r_range_low) ? 33'(r_range_low) : r_sum2;
    assign w_hi_clamp = (w_lo_clamp > r_range_high) ? 33'(r_range_high) : w_lo_clamp;

    always_ff @(posedge i_clk) begin
        r_x3     <= r_ctl2.eval ? w_hi_clamp[31:0] : r_sum2[31:0];
        r_caddr3 <= r_caddr2;
    end

    // stage 4: offset from the table origin
    logic signed [32:0] w_off;
    logic [31:0]        r_off4;
    logic               r_offpos4;
    logic signed [31:0] r_x4;
    logic [SEG_W-1:0]   r_caddr4;

    assign w_off = 33'(r_x3) - 33'(r_range_low);

    always_ff @(posedge i_clk) begin
        r_off4    <= w_off[31:0];
        r_offpos4 <= !w_off[32] && (w_off != '0);
        r_x4      <= r_x3;
        r_caddr4  <= r_caddr3;
    end

    // stage 5: offset times segment scale, integer part kept
    logic [63:0]        w_prod;
    logic [31:0]        r_prod_hi5;
    logic               r_offpos5;
    logic signed [31:0] r_x5;
    logic [SEG_W-1:0]   r_caddr5;

    assign w_prod = 64'(r_off4) * 64'(r_seg_scale);

    always_ff @(posedge i_clk) begin
        r_prod_hi5 <= w_prod[63:32];
        r_offpos5  <= r_offpos4;
        r_x5       <= r_x4;
        r_caddr5   <= r_caddr4;
    end

    // stage 6: coefficient memory, one lane each for quad, lin, const from the low end;
    // loads write here so they stay in order with reads
    logic [3*DataW-1:0] r_coef_mem [SEGMENTS];
    logic [SEG_W-1:0]   w_seg;
    logic [SEG_W-1:0]   w_tab_addr;
    logic signed [31:0] r_c2_6;
    logic signed [31:0] r_c1_6;
    logic signed [31:0] r_c0_6;
    logic signed [31:0] r_x6;

    always_comb begin
        if (!r_offpos5) begin
            w_seg = '0;
        end else if (r_prod_hi5 > 32'(SEGMENTS - 1)) begin
            w_seg = SEG_W'(SEGMENTS - 1);
        end else begin
            w_seg = r_prod_hi5[SEG_W-1:0];
        end
    end

    assign w_tab_addr = r_ctl5.eval ? w_seg : r_caddr5;

    always_ff @(posedge i_clk) begin
        if (r_ctl5.coef_we[0]) begin
            r_coef_mem[w_tab_addr][DataW-1:0] <= r_x5;
        end
        if (r_ctl5.coef_we[1]) begin
            r_coef_mem[w_tab_addr][2*DataW-1:DataW] <= r_x5;
        end
        if (r_ctl5.coef_we[2]) begin
            r_coef_mem[w_tab_addr][3*DataW-1:2*DataW] <= r_x5;
        end
        r_c2_6 <= r_coef_mem[w_tab_addr][DataW-1:0];
        r_c1_6 <= r_coef_mem[w_tab_addr][2*DataW-1:DataW];
        r_c0_6 <= r_coef_mem[w_tab_addr][3*DataW-1:2*DataW];
        r_x6   <= r_x5;
    end

    // stage 7: c2 * x
    logic signed [63:0] r_p7;
    logic signed [31:0] r_c1_7;
    logic signed [31:0] r_c0_7;
    logic signed [31:0] r_x7;

    always_ff @(posedge i_clk) begin
        r_p7   <= 64'(r_c2_6) * 64'(r_x6);
        r_c1_7 <= r_c1_6;
        r_c0_7 <= r_c0_6;
        r_x7   <= r_x6;
    end

    // stage 8: floor to q16.16, add c1, saturate
    logic signed [48:0] w_t_full;
    t_sat               w_sat_t;
    logic signed [31:0] r_t8;
    logic               r_clip8;
    logic signed [31:0] r_c0_8;
    logic signed [31:0] r_x8;

    assign w_t_full = 49'($signed(r_p7[63:16])) + 49'(r_c1_7);
    assign w_sat_t  = sat_q16(w_t_full);

    always_ff @(posedge i_clk) begin
        r_t8    <= w_sat_t.val;
        r_clip8 <= w_sat_t.clip;
        r_c0_8  <= r_c0_7;
        r_x8    <= r_x7;
    end

    // stage 9: t * x
    logic signed [63:0] r_p9;
    logic               r_clip9;
    logic signed [31:0] r_c0_9;

    always_ff @(posedge i_clk) begin
        r_p9    <= 64'(r_t8) * 64'(r_x8);
        r_clip9 <= r_clip8;
        r_c0_9  <= r_c0_8;
    end

    // final add and saturate, straight into the output queue
    logic signed [48:0] w_r_full;
    t_sat               w_sat_r;
    t_res               w_res;

    assign w_r_full     = 49'($signed(r_p9[63:16])) + 49'(r_c0_9);
    assign w_sat_r      = sat_q16(w_r_full);
    assign w_res.result = w_sat_r.val;
    assign w_res.last   = r_ctl9.last;
    assign w_res.sat    = w_sat_r.clip || r_clip9;

    // output queue; r_count tracks accepted evaluates not yet taken
    t_res             r_fifo [DEPTH];
    logic [PTR_W:0]   r_wr_ptr;
    logic [PTR_W:0]   r_rd_ptr;
    logic [PTR_W:0]   w_fill;
    t_res             w_head;

    assign w_fill          = r_wr_ptr - r_rd_ptr;
    assign w_head          = r_fifo[r_rd_ptr[PTR_W-1:0]];
    assign o_m_axis_tvalid = (r_wr_ptr != r_rd_ptr);
    assign o_m_axis_tdata  = w_head.result;
    assign o_m_axis_tuser  = w_head.sat;
    assign o_m_axis_tlast  = w_head.last;
    assign w_pop           = o_m_axis_tvalid && i_m_axis_tready;
    assign o_s_axis_tready = (r_count != CNT_W'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (r_ctl9.eval) begin
            r_fifo[r_wr_ptr[PTR_W-1:0]] <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (r_ctl9.eval) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_ctl_in.eval, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // checks
    a_fill_le_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CNT_W'(w_fill) <= r_count)
        else $error("output queue holds more results than are outstanding");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("outstanding result count above queue depth");

    a_push_needs_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl9.eval |-> (r_count != '0))
        else $error("result written with no outstanding evaluate");

    a_no_write_on_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl5.eval |-> (r_ctl5.coef_we == 3'b000))
        else $error("coefficient write collides with a table read");

    a_pop_moves_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> (r_rd_ptr == $past(r_rd_ptr) + 1'b1))
        else $error("read pointer did not advance on a result transfer");

endmodule

`default_nettype wire
